/* hdl/izh_pkg.sv */
// shared types, constants and helpers of the izhikevich neuron vector step core
`default_nettype none
package izh_pkg;
	// vector size and derived widths
	localparam int NEURONS = 2;
	localparam int IDX_W = (NEURONS > 1) ? $clog2(NEURONS) : 1;
	localparam int CNT_W = $clog2(NEURONS + 1);
	localparam int DATA_W = 32;
	localparam int STEP_W = 31;
	localparam int ADDR_W = 5;

	// command queue and result queue sizes
	localparam int CMDQ_DEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;
	localparam int RES_DEPTH = 2;

	// register map, index is the word address
	typedef enum logic [2:0] {
		REG_THRESHOLD = 3'd0,
		REG_RATE_A = 3'd1,
		REG_SENS_B = 3'd2,
		REG_RESET_MEM = 3'd3,
		REG_RESET_REC = 3'd4,
		REG_STEP = 3'd5,
		REG_RESTING = 3'd6
	} reg_idx_t;

	// register reset values, Q8.24
	localparam logic signed [31:0] THRESHOLD_RST = 32'sd3019899;
	localparam logic signed [31:0] RATE_A_RST = 32'sd336;
	localparam logic signed [31:0] SENS_B_RST = 32'sd587203;
	localparam logic signed [31:0] RESET_MEM_RST = -32'sd922747;
	localparam logic signed [31:0] RESET_REC_RST = 32'sd838861;
	localparam logic [30:0] STEP_RST = 31'd167772;
	localparam logic signed [31:0] RESTING_RST = -32'sd1090519;

	// state after reset: v = e, u = floor(b*e)
	localparam logic signed [63:0] REC_PROD = 64'sd587203 * -64'sd1090519;
	localparam logic signed [31:0] MEMB_RST = RESTING_RST;
	localparam logic signed [31:0] REC_RST = REC_PROD[55:24];

	// model constants, 0.04 and 140 in Q8.24
	localparam logic signed [32:0] Q_POINT04 = 33'sd671089;
	localparam logic signed [37:0] Q_ONEFORTY = 38'sd2348810240;

	// saturation bounds
	localparam logic signed [47:0] SAT_HI = 48'sd2147483647;
	localparam logic signed [47:0] SAT_LO = -48'sd2147483648;

	// live configuration
	typedef struct packed {
		logic signed [31:0] threshold;
		logic signed [31:0] rate_a;
		logic signed [31:0] sens_b;
		logic signed [31:0] reset_mem;
		logic signed [31:0] reset_rec;
		logic [30:0] step;
	} cfg_t;

	// classified request from the front part
	typedef struct packed {
		logic compute;
		logic close;
		logic [IDX_W-1:0] idx;
		logic signed [31:0] current;
	} cmd_t;

	// engine request and response
	typedef struct packed {
		logic start;
		logic signed [31:0] v;
		logic signed [31:0] u;
		logic signed [31:0] cur;
	} eng_req_t;

	typedef struct packed {
		logic done;
		logic signed [31:0] vn;
		logic signed [31:0] un;
	} eng_rsp_t;

	// back part status
	typedef struct packed {
		logic engine_busy;
		logic sweeping;
	} bk_stat_t;

	// clamp to signed 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
		if (x > SAT_HI) begin
			sat32 = 32'sh7fffffff;
		end else if (x < SAT_LO) begin
			sat32 = 32'sh80000000;
		end else begin
			sat32 = x[31:0];
		end
	endfunction
endpackage
`default_nettype wire

/* hdl/izh_front.sv */
// front part: takes input requests, tracks the neuron index and classifies them
`default_nettype none
module izh_front (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic signed [izh_pkg::DATA_W-1:0] current,
	input logic last,
	input logic cq_full,
	output logic cq_push,
	output izh_pkg::cmd_t cq_cmd
);
	import izh_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	logic accept;
	logic in_range;

	// accept whenever the command queue has room
	assign full = cq_full;
	assign accept = push && !cq_full;
	assign in_range = (cnt_q < CNT_W'(NEURONS));

	// extra non-closing requests are dropped here
	assign cq_push = accept && (in_range || last);

	always_comb begin
		cq_cmd.compute = in_range;
		cq_cmd.close = last;
		cq_cmd.idx = cnt_q[IDX_W-1:0];
		cq_cmd.current = current;
	end

	// neuron counter, cleared by the closing request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			if (last) begin
				cnt_q <= '0;
			end else if (in_range) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end
endmodule
`default_nettype wire

/* hdl/izh_cmd_queue.sv */
// short command queue between the front and the back part
`default_nettype none
module izh_cmd_queue (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input izh_pkg::cmd_t wr_cmd,
	output logic full,
	input logic rd_en,
	output izh_pkg::cmd_t rd_cmd,
	output logic empty,
	output logic [izh_pkg::QCNT_W-1:0] count
);
	import izh_pkg::*;

	cmd_t slot_q [CMDQ_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic do_wr;
	logic do_rd;

	assign full = (cnt_q == QCNT_W'(CMDQ_DEPTH));
	assign empty = (cnt_q == '0);
	assign count = cnt_q;
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_cmd = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + QCNT_W'(do_wr) - QCNT_W'(do_rd);
		end
	end
endmodule
`default_nettype wire

/* hdl/izh_engine.sv */
// one neuron update on a single shared multiplier, one product per cycle
`default_nettype none
module izh_engine (
	input logic clk,
	input logic arst_n,
	input izh_pkg::cfg_t cfg,
	input izh_pkg::eng_req_t req,
	output izh_pkg::eng_rsp_t rsp
);
	import izh_pkg::*;

	typedef enum logic [9:0] {
		E_IDLE = 10'b0000000001,
		E_VV = 10'b0000000010,
		E_BV = 10'b0000000100,
		E_SL = 10'b0000001000,
		E_SH = 10'b0000010000,
		E_AD = 10'b0000100000,
		E_HD = 10'b0001000000,
		E_HI = 10'b0010000000,
		E_WR = 10'b0100000000,
		E_DN = 10'b1000000000
	} eng_st_t;

	eng_st_t st_q;
	logic signed [31:0] v_q;
	logic signed [31:0] u_q;
	logic signed [31:0] cur_q;
	logic [38:0] sq_q;
	logic signed [37:0] lin_q;
	logic signed [31:0] d1_q;
	logic [39:0] acc_q;
	logic [35:0] quad_q;
	logic signed [31:0] inner_q;
	logic signed [31:0] un_q;
	logic signed [31:0] vn_q;
	logic signed [63:0] prod_q;

	logic signed [32:0] mult_a;
	logic signed [32:0] mult_b;
	logic signed [65:0] prod_full;
	logic signed [39:0] prod_fl;
	logic [39:0] quad_sum;
	logic signed [37:0] lin_w;

	// floor of the last product by 2^24
	assign prod_fl = $signed(prod_q[63:24]);

	// 5v + 140 - u + I
	assign lin_w = (38'(v_q) <<< 2) + 38'(v_q) + Q_ONEFORTY - 38'(u_q) + 38'(cur_q);

	// v*v*0.04 from the two partial products of the square
	assign quad_sum = {20'b0, acc_q[39:20]} + {1'b0, prod_q[38:0]};

	// operand selection for the shared multiplier
	always_comb begin
		mult_a = '0;
		mult_b = '0;
		case (st_q)
			E_VV: begin
				mult_a = 33'(v_q);
				mult_b = 33'(v_q);
			end
			E_BV: begin
				mult_a = 33'(cfg.sens_b);
				mult_b = 33'(v_q);
			end
			E_SL: begin
				mult_a = $signed({13'b0, sq_q[19:0]});
				mult_b = Q_POINT04;
			end
			E_SH: begin
				mult_a = $signed({14'b0, sq_q[38:20]});
				mult_b = Q_POINT04;
			end
			E_AD: begin
				mult_a = 33'(cfg.rate_a);
				mult_b = 33'(d1_q);
			end
			E_HD: begin
				mult_a = $signed({2'b0, cfg.step});
				mult_b = 33'(sat32(48'(prod_fl)));
			end
			E_HI: begin
				mult_a = $signed({2'b0, cfg.step});
				mult_b = 33'(inner_q);
			end
			default: begin
				mult_a = '0;
				mult_b = '0;
			end
		endcase
	end

	assign prod_full = mult_a * mult_b;

	// product register
	always_ff @(posedge clk) begin
		prod_q <= prod_full[63:0];
	end

	// intermediate values
	always_ff @(posedge clk) begin
		case (st_q)
			E_IDLE: begin
				if (req.start) begin
					v_q <= req.v;
					u_q <= req.u;
					cur_q <= req.cur;
				end
			end
			E_BV: begin
				sq_q <= prod_q[62:24];
				lin_q <= lin_w;
			end
			E_SL: begin
				d1_q <= sat32(48'(prod_fl) - 48'(u_q));
			end
			E_SH: begin
				acc_q <= prod_q[39:0];
			end
			E_AD: begin
				quad_q <= quad_sum[39:4];
			end
			E_HD: begin
				inner_q <= sat32(48'($signed({1'b0, quad_q})) + 48'(lin_q));
			end
			E_HI: begin
				un_q <= sat32(48'(u_q) + 48'(prod_fl));
			end
			E_WR: begin
				vn_q <= sat32(48'(v_q) + 48'(prod_fl));
			end
			default: begin
			end
		endcase
	end

	// step sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= E_IDLE;
		end else begin
			case (st_q)
				E_IDLE: if (req.start) st_q <= E_VV;
				E_VV: st_q <= E_BV;
				E_BV: st_q <= E_SL;
				E_SL: st_q <= E_SH;
				E_SH: st_q <= E_AD;
				E_AD: st_q <= E_HD;
				E_HD: st_q <= E_HI;
				E_HI: st_q <= E_WR;
				E_WR: st_q <= E_DN;
				E_DN: st_q <= E_IDLE;
				default: st_q <= E_IDLE;
			endcase
		end
	end

	assign rsp.done = (st_q == E_DN);
	assign rsp.vn = vn_q;
	assign rsp.un = un_q;
endmodule
`default_nettype wire

/* hdl/izh_back.sv */
// back part: neuron stores, update sequencing, commit sweep and result queue
`default_nettype none
module izh_back (
	input logic clk,
	input logic arst_n,
	input izh_pkg::cfg_t cfg,
	input logic cmd_valid,
	input izh_pkg::cmd_t cmd,
	output logic cmd_pop,
	output izh_pkg::eng_req_t eng_req,
	input izh_pkg::eng_rsp_t eng_rsp,
	output izh_pkg::bk_stat_t stat,
	output logic empty,
	input logic pop,
	output logic signed [izh_pkg::DATA_W-1:0] membrane,
	output logic spiked,
	output logic last_out
);
	import izh_pkg::*;

	typedef enum logic [5:0] {
		B_IDLE = 6'b000001,
		B_RD = 6'b000010,
		B_LOAD = 6'b000100,
		B_WAIT = 6'b001000,
		B_SRD = 6'b010000,
		B_SWR = 6'b100000
	} bk_st_t;

	typedef struct packed {
		logic signed [31:0] membrane;
		logic spiked;
		logic last;
	} res_t;

	bk_st_t st_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] next_q;
	logic close_q;
	logic signed [31:0] cur_q;
	logic all_above_q;
	logic primed_q;

	// neuron stores and pending values
	logic signed [31:0] memb_mem [NEURONS];
	logic signed [31:0] rec_mem [NEURONS];
	logic signed [31:0] pend_v_mem [NEURONS];
	logic signed [31:0] pend_u_mem [NEURONS];
	logic signed [31:0] v_rd_q;
	logic signed [31:0] u_rd_q;
	logic signed [31:0] pv_rd_q;
	logic signed [31:0] pu_rd_q;

	// result queue
	res_t res_q [RES_DEPTH];
	logic [QPTR_W-1:0] res_wr_q;
	logic [QPTR_W-1:0] res_rd_q;
	logic [QCNT_W-1:0] res_cnt_q;
	logic res_full;
	logic res_push;
	logic res_pop;
	res_t res_new;

	logic sweep_wr;
	logic pend_we;
	logic sweep_end;
	logic more_fill;
	logic signed [31:0] commit_v;
	logic signed [31:0] commit_u;

	assign cmd_pop = (st_q == B_IDLE) && cmd_valid;
	assign pend_we = (st_q == B_WAIT) && eng_rsp.done;
	assign res_full = (res_cnt_q == QCNT_W'(RES_DEPTH));
	assign sweep_wr = (st_q == B_SWR) && !res_full;
	assign res_push = sweep_wr;
	assign res_pop = pop && !empty;
	assign sweep_end = (idx_q == IDX_W'(NEURONS - 1));
	assign more_fill = (next_q < CNT_W'(NEURONS));

	// committed values: reset values on a spike, else the pending ones
	assign commit_v = all_above_q ? cfg.reset_mem : pv_rd_q;
	assign commit_u = all_above_q ? cfg.reset_rec : pu_rd_q;

	// engine request, stores read as reset values until the first commit
	always_comb begin
		eng_req.start = (st_q == B_LOAD);
		eng_req.v = primed_q ? v_rd_q : MEMB_RST;
		eng_req.u = primed_q ? u_rd_q : REC_RST;
		eng_req.cur = cur_q;
	end

	assign stat.engine_busy = (st_q == B_WAIT);
	assign stat.sweeping = (st_q == B_SRD) || (st_q == B_SWR);

	// store memories
	always_ff @(posedge clk) begin
		if (sweep_wr) begin
			memb_mem[idx_q] <= commit_v;
			rec_mem[idx_q] <= commit_u;
		end
		if (st_q == B_RD) begin
			v_rd_q <= memb_mem[idx_q];
			u_rd_q <= rec_mem[idx_q];
		end
	end

	// pending memories
	always_ff @(posedge clk) begin
		if (pend_we) begin
			pend_v_mem[idx_q] <= eng_rsp.vn;
			pend_u_mem[idx_q] <= eng_rsp.un;
		end
		if (st_q == B_SRD) begin
			pv_rd_q <= pend_v_mem[idx_q];
			pu_rd_q <= pend_u_mem[idx_q];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
			idx_q <= '0;
			next_q <= '0;
			close_q <= 1'b0;
			cur_q <= '0;
			all_above_q <= 1'b1;
			primed_q <= 1'b0;
		end else begin
			case (st_q)
				B_IDLE: begin
					if (cmd_valid) begin
						close_q <= cmd.close;
						if (cmd.compute) begin
							idx_q <= cmd.idx;
							cur_q <= cmd.current;
							next_q <= CNT_W'(cmd.idx) + CNT_W'(1);
							st_q <= B_RD;
						end else begin
							idx_q <= '0;
							next_q <= CNT_W'(NEURONS);
							st_q <= B_SRD;
						end
					end
				end
				B_RD: st_q <= B_LOAD;
				B_LOAD: st_q <= B_WAIT;
				B_WAIT: begin
					if (eng_rsp.done) begin
						if (!(eng_rsp.vn > cfg.threshold)) begin
							all_above_q <= 1'b0;
						end
						if (close_q && more_fill) begin
							// neurons without a current this vector run with zero
							idx_q <= next_q[IDX_W-1:0];
							next_q <= next_q + CNT_W'(1);
							cur_q <= '0;
							st_q <= B_RD;
						end else if (close_q) begin
							idx_q <= '0;
							st_q <= B_SRD;
						end else begin
							st_q <= B_IDLE;
						end
					end
				end
				B_SRD: st_q <= B_SWR;
				B_SWR: begin
					if (!res_full) begin
						if (sweep_end) begin
							primed_q <= 1'b1;
							all_above_q <= 1'b1;
							idx_q <= '0;
							st_q <= B_IDLE;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
							st_q <= B_SRD;
						end
					end
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	// result queue storage
	always_comb begin
		res_new.membrane = commit_v;
		res_new.spiked = all_above_q;
		res_new.last = sweep_end;
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_q[res_wr_q] <= res_new;
		end
	end

	// result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_q <= '0;
			res_rd_q <= '0;
			res_cnt_q <= '0;
		end else begin
			if (res_push) begin
				res_wr_q <= (res_wr_q == QPTR_W'(RES_DEPTH - 1)) ? '0 : res_wr_q + QPTR_W'(1);
			end
			if (res_pop) begin
				res_rd_q <= (res_rd_q == QPTR_W'(RES_DEPTH - 1)) ? '0 : res_rd_q + QPTR_W'(1);
			end
			res_cnt_q <= res_cnt_q + QCNT_W'(res_push) - QCNT_W'(res_pop);
		end
	end

	assign empty = (res_cnt_q == '0);
	assign membrane = res_q[res_rd_q].membrane;
	assign spiked = res_q[res_rd_q].spiked;
	assign last_out = res_q[res_rd_q].last;
endmodule
`default_nettype wire

/* hdl/izhikevich_neuron_vector_step_core.sv */
// top level: configuration registers, front part, command queue, back part
// Per neuron request: store read, engine load, 7 products on the one shared
// multiplier, pending write; the closing request also runs each neuron that got no
// current, then the commit sweep writes each result, waiting while the result queue is full.
// Reset: registers take their defaults, stores read as the resting state until
// the first commit; no clearing pass.
`default_nettype none
module izhikevich_neuron_vector_step_core (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic signed [izh_pkg::DATA_W-1:0] current,
	input logic last,
	output logic empty,
	input logic pop,
	output logic signed [izh_pkg::DATA_W-1:0] membrane,
	output logic spiked,
	output logic last_out,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [izh_pkg::ADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import izh_pkg::*;

	cfg_t cfg_q;
	logic signed [31:0] resting_q;
	reg_idx_t reg_idx;
	logic cfg_wr;

	logic cq_full;
	logic cq_push;
	cmd_t cq_wr_cmd;
	cmd_t cq_rd_cmd;
	logic cq_empty;
	logic cq_pop;
	logic [QCNT_W-1:0] cq_count;
	eng_req_t eng_req;
	eng_rsp_t eng_rsp;
	bk_stat_t bk_stat;

	// configuration port
	assign pready = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold <= THRESHOLD_RST;
			cfg_q.rate_a <= RATE_A_RST;
			cfg_q.sens_b <= SENS_B_RST;
			cfg_q.reset_mem <= RESET_MEM_RST;
			cfg_q.reset_rec <= RESET_REC_RST;
			cfg_q.step <= STEP_RST;
			resting_q <= RESTING_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_THRESHOLD: cfg_q.threshold <= pwdata;
				REG_RATE_A: cfg_q.rate_a <= pwdata;
				REG_SENS_B: cfg_q.sens_b <= pwdata;
				REG_RESET_MEM: cfg_q.reset_mem <= pwdata;
				REG_RESET_REC: cfg_q.reset_rec <= pwdata;
				REG_STEP: cfg_q.step <= pwdata[30:0];
				REG_RESTING: resting_q <= pwdata;
				default: begin
				end
			endcase
		end
	end

	// register readback
	always_comb begin
		case (reg_idx)
			REG_THRESHOLD: prdata = cfg_q.threshold;
			REG_RATE_A: prdata = cfg_q.rate_a;
			REG_SENS_B: prdata = cfg_q.sens_b;
			REG_RESET_MEM: prdata = cfg_q.reset_mem;
			REG_RESET_REC: prdata = cfg_q.reset_rec;
			REG_STEP: prdata = {1'b0, cfg_q.step};
			REG_RESTING: prdata = resting_q;
			default: prdata = '0;
		endcase
	end

	// front part
	izh_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.current(current),
		.last(last),
		.cq_full(cq_full),
		.cq_push(cq_push),
		.cq_cmd(cq_wr_cmd)
	);

	// queue between the parts
	izh_cmd_queue u_cmd_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(cq_push),
		.wr_cmd(cq_wr_cmd),
		.full(cq_full),
		.rd_en(cq_pop),
		.rd_cmd(cq_rd_cmd),
		.empty(cq_empty),
		.count(cq_count)
	);

	// back part
	izh_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.cmd_valid(!cq_empty),
		.cmd(cq_rd_cmd),
		.cmd_pop(cq_pop),
		.eng_req(eng_req),
		.eng_rsp(eng_rsp),
		.stat(bk_stat),
		.empty(empty),
		.pop(pop),
		.membrane(membrane),
		.spiked(spiked),
		.last_out(last_out)
	);

	// neuron arithmetic
	izh_engine u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.req(eng_req),
		.rsp(eng_rsp)
	);

	// command queue never overfills
	a_cq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cq_count <= QCNT_W'(CMDQ_DEPTH))
		else $error("command queue over its depth");

	// a closing request always reaches the back part
	a_close_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && last) |=> !cq_empty)
		else $error("closing request lost");

	// engine finishes only while the back part waits for it
	a_eng_done: assert property (@(posedge clk) disable iff (!arst_n)
		eng_rsp.done |-> bk_stat.engine_busy)
		else $error("engine result without a waiting request");

	// no command is taken during the commit sweep
	a_no_pop_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.sweeping |-> !cq_pop)
		else $error("command taken during commit sweep");
endmodule
`default_nettype wire
